@@ hw/rtl/spsc_pkg.sv @@
// shared types and codes for the successor position search core
// no dependencies
package spsc_pkg;

    localparam int KEY_W = 16;
    localparam int POS_W = 12;

    typedef logic [KEY_W-1:0] t_key;
    typedef logic [POS_W-1:0] t_pos;

    typedef enum logic [1:0] {
        FUNC_CLEAR  = 2'd0,
        FUNC_APPEND = 2'd1,
        FUNC_QUERY  = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } t_state;

    // one compare step of the scan
    typedef struct packed {
        logic valid;
        logic first;
    } t_scan_ctl;

    typedef struct packed {
        t_pos pos;
        logic greater;
    } t_scan_res;

endpackage

@@ hw/rtl/spsc_if.sv @@
// valid/ready channel interfaces for the successor position search core
// no dependencies
interface spsc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [15:0] key_value;

    modport source(output valid, output func, output key_value, input ready);
    modport sink(input valid, input func, input key_value, output ready);
endinterface

interface spsc_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] succ_pos;
    logic        found_greater;
    logic [1:0]  status;

    modport source(output valid, output succ_pos, output found_greater,
                   output status, input ready);
    modport sink(input valid, input succ_pos, input found_greater,
                 input status, output ready);
endinterface

@@ hw/rtl/spsc_ram.sv @@
// generic single write port, single read port ram with registered read
// no dependencies
module spsc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/spsc_scan.sv @@
// running minimum-greater and maximum tracker, one stored key per cycle
// depends on spsc_pkg
module spsc_scan #(
    parameter int AW = 9
) (
    input  logic                 i_clk,
    input  spsc_pkg::t_scan_ctl  i_ctl,
    input  spsc_pkg::t_key       i_query,
    input  spsc_pkg::t_key       i_data,
    input  logic [AW-1:0]        i_idx,
    output spsc_pkg::t_scan_res  o_res
);
    import spsc_pkg::*;

    t_key          r_max;
    logic [AW-1:0] r_max_idx;
    t_key          r_min;
    logic [AW-1:0] r_min_idx;
    logic          r_any;

    logic w_gt_q;

    assign w_gt_q = i_data > i_query;

    // strict compares keep the earliest position among equal keys
    always_ff @(posedge i_clk) begin
        if (i_ctl.valid) begin
            if (i_ctl.first) begin
                r_max     <= i_data;
                r_max_idx <= i_idx;
                r_any     <= w_gt_q;
                r_min     <= i_data;
                r_min_idx <= i_idx;
            end else begin
                if (i_data > r_max) begin
                    r_max     <= i_data;
                    r_max_idx <= i_idx;
                end
                if (w_gt_q && (!r_any || i_data < r_min)) begin
                    r_any     <= 1'b1;
                    r_min     <= i_data;
                    r_min_idx <= i_idx;
                end
            end
        end
    end

    assign o_res.pos     = r_any ? POS_W'(r_min_idx) : POS_W'(r_max_idx);
    assign o_res.greater = r_any;

endmodule

@@ hw/rtl/successor_position_search_core.sv @@
// top level of the successor position search core
// depends on spsc_pkg, spsc_if, spsc_ram, spsc_scan
//
//  channel | dir | modport | payload
//  i_in    | in  | sink    | func, key_value
//  o_out   | out | source  | succ_pos, found_greater, status
//
// clear, append and unused codes: result registered in the cycle the command is taken
// query: S_SCAN, S_DRAIN, S_DONE for N stored keys, one key read per cycle from the key ram
// reset clears the entry count and the control state, the key ram is not cleared
// input is taken only in idle with the output register free or being drained
module successor_position_search_core #(
    parameter int TABLE_DEPTH = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    spsc_in_if.sink     i_in,
    spsc_out_if.source  o_out
);
    import spsc_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_rd_addr, n_rd_addr;
    t_key          r_key;
    logic          r_cmp_valid;
    logic [AW-1:0] r_cmp_idx;

    logic          r_out_valid;
    t_pos          r_out_pos;
    logic          r_out_greater;
    t_status       r_out_status;

    logic          w_out_free;
    logic          w_in_acc;
    logic          w_key_load;
    logic          w_out_load;
    t_pos          w_out_pos;
    logic          w_out_greater;
    t_status       w_out_status;
    logic          w_we;
    t_key          w_rdata;
    logic          w_last;
    t_scan_ctl     w_ctl;
    t_scan_res     w_res;

    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_in_acc   = i_in.valid && (r_state == S_IDLE) && w_out_free;
    assign w_last     = CW'(r_rd_addr) == (r_count - CW'(1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc && t_func'(i_in.func) == FUNC_QUERY && r_count != '0) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        i_in.ready    = 1'b0;
        n_count       = r_count;
        n_rd_addr     = r_rd_addr;
        w_key_load    = 1'b0;
        w_we          = 1'b0;
        w_out_load    = 1'b0;
        w_out_pos     = '0;
        w_out_greater = 1'b0;
        w_out_status  = ST_OK;
        case (r_state)
            S_IDLE: begin
                i_in.ready = w_out_free;
                if (w_in_acc) begin
                    case (t_func'(i_in.func))
                        FUNC_CLEAR: begin
                            n_count    = '0;
                            w_out_load = 1'b1;
                        end
                        FUNC_APPEND: begin
                            w_out_load = 1'b1;
                            if (r_count == CW'(TABLE_DEPTH)) begin
                                w_out_status = ST_FULL;
                            end else begin
                                w_we    = 1'b1;
                                n_count = r_count + CW'(1);
                            end
                        end
                        FUNC_QUERY: begin
                            if (r_count == '0) begin
                                w_out_load   = 1'b1;
                                w_out_status = ST_EMPTY;
                            end else begin
                                w_key_load = 1'b1;
                                n_rd_addr  = '0;
                            end
                        end
                        default: begin
                            w_out_load = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (!w_last) begin
                    n_rd_addr = r_rd_addr + AW'(1);
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    w_out_load    = 1'b1;
                    w_out_pos     = w_res.pos;
                    w_out_greater = w_res.greater;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_cmp_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_cmp_valid <= r_state == S_SCAN;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_addr <= n_rd_addr;
        r_cmp_idx <= r_rd_addr;
        if (w_key_load) begin
            r_key <= i_in.key_value;
        end
        if (w_out_load) begin
            r_out_pos     <= w_out_pos;
            r_out_greater <= w_out_greater;
            r_out_status  <= w_out_status;
        end
    end

    spsc_ram #(
        .WIDTH(KEY_W),
        .DEPTH(TABLE_DEPTH)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_in.key_value),
        .i_raddr (r_rd_addr),
        .o_rdata (w_rdata)
    );

    assign w_ctl.valid = r_cmp_valid;
    assign w_ctl.first = r_cmp_idx == '0;

    spsc_scan #(
        .AW(AW)
    ) u_scan (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_query (r_key),
        .i_data  (w_rdata),
        .i_idx   (r_cmp_idx),
        .o_res   (w_res)
    );

    assign o_out.valid         = r_out_valid;
    assign o_out.succ_pos      = r_out_pos;
    assign o_out.found_greater = r_out_greater;
    assign o_out.status        = r_out_status;

endmodule
